// File: src/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on clk_i and stay quiet
// while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true at a sampled edge.
`define RMQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int unsigned DATA_W      = 32;  // matrix and quaternion words
  localparam int unsigned LIMIT_W     = 31;  // near-zero limit register
  localparam int unsigned RAD_W       = 33;  // clamped radicand, unsigned
  localparam int unsigned DIFF_W      = 33;  // sum/difference of two entries
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1074;

  // Quaternion component slots; x, y, z double as the matrix axis index.
  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2,
    COMP_W = 2'd3
  } comp_e;

  // One rotation matrix, rows right, up, at.
  typedef struct packed {
    logic signed [DATA_W-1:0] right_x;
    logic signed [DATA_W-1:0] right_y;
    logic signed [DATA_W-1:0] right_z;
    logic signed [DATA_W-1:0] up_x;
    logic signed [DATA_W-1:0] up_y;
    logic signed [DATA_W-1:0] up_z;
    logic signed [DATA_W-1:0] at_x;
    logic signed [DATA_W-1:0] at_y;
    logic signed [DATA_W-1:0] at_z;
  } mat_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [RAD_W-1:0]             rad;        // radicand before scaling
    logic [3:0][DIFF_W-1:0]       diff;       // numerator per slot, signed
    comp_e                        half_sel;   // slot that takes root/2
    logic                         trace_pos;  // trace path taken
  } item_t;

endpackage

`default_nettype wire

// File: src/rotation_matrix_to_quaternion_top.sv
// Pipeline: classify stages A and B, the request queue, ROOT_W root stages with
//   ROOT_W = (34 + FRAC_BITS) / 2, a setup stage, 32 divide stages, output reg.
// Throughput: one matrix per cycle unless out_stall_i holds the output; the root and
//   divider pipelines take one every cycle; a 4-entry queue decouples the classifier.
// Reset: asynchronous, active low; clears all valid flags and the queue and loads
//   near_zero_limit with 1074. No clearing pass.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Converts a Q2.30 rotation matrix into a saturated Q2.30 quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_top #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // near_zero_limit write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i,
  // matrix requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] right_x_i,
  input  logic signed [31:0] right_y_i,
  input  logic signed [31:0] right_z_i,
  input  logic signed [31:0] up_x_i,
  input  logic signed [31:0] up_y_i,
  input  logic signed [31:0] up_z_i,
  input  logic signed [31:0] at_x_i,
  input  logic signed [31:0] at_y_i,
  input  logic signed [31:0] at_z_i,
  // quaternion results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] quat_x_o,
  output logic signed [31:0] quat_y_o,
  output logic signed [31:0] quat_z_o,
  output logic signed [31:0] quat_w_o,
  output logic        degenerate_o
);

  // Configuration register
  logic [rmq_pkg::LIMIT_W-1:0] limit_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= rmq_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  rmq_pkg::mat_t  mat;
  rmq_pkg::item_t push_item, pop_item;
  logic           push, pop, q_full, q_empty;

  assign mat.right_x = right_x_i;
  assign mat.right_y = right_y_i;
  assign mat.right_z = right_z_i;
  assign mat.up_x    = up_x_i;
  assign mat.up_y    = up_y_i;
  assign mat.up_z    = up_z_i;
  assign mat.at_x    = at_x_i;
  assign mat.at_y    = at_y_i;
  assign mat.at_z    = at_z_i;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mat_i      (mat),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  rmq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  logic [31:0] qx, qy, qz, qw;

  rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .item_i       (pop_item),
    .pop_o        (pop),
    .limit_i      (limit_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .quat_x_o     (qx),
    .quat_y_o     (qy),
    .quat_z_o     (qz),
    .quat_w_o     (qw),
    .degenerate_o (degenerate_o)
  );

  assign quat_x_o = signed'(qx);
  assign quat_y_o = signed'(qy);
  assign quat_z_o = signed'(qz);
  assign quat_w_o = signed'(qw);

endmodule

`default_nettype wire

// File: src/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Accepts matrices, picks the path and axis, forms radicand and numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rmq_pkg::mat_t  mat_i,
  input  logic           q_full_i,
  output logic           push_o,
  output rmq_pkg::item_t item_o
);

  localparam logic signed [34:0] ONE = 35'(64'd1 << FRAC_BITS);

  // Stage A: trace and largest-diagonal axis
  logic                 a_valid_q;
  rmq_pkg::mat_t        mat_q;
  logic signed [33:0]   trace_d, trace_q;
  rmq_pkg::comp_e       axis_d, axis_q;
  logic signed [31:0]   diag_sel;

  always_comb begin
    trace_d = 34'(mat_i.right_x) + 34'(mat_i.up_y) + 34'(mat_i.at_z);
    if (mat_i.up_y > mat_i.right_x) begin
      axis_d   = rmq_pkg::COMP_Y;
      diag_sel = mat_i.up_y;
    end else begin
      axis_d   = rmq_pkg::COMP_X;
      diag_sel = mat_i.right_x;
    end
    if (mat_i.at_z > diag_sel) begin
      axis_d = rmq_pkg::COMP_Z;
    end
  end

  assign in_stall_o = a_valid_q && q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      mat_q   <= mat_i;
      trace_q <= trace_d;
      axis_q  <= axis_d;
    end
  end

  // Stage B: route entries by axis i, with j, k following cyclically
  logic signed [31:0] mii, mjj, mkk, mkj, mjk, mji, mij, mki, mik;
  logic signed [34:0] rad_full;
  logic signed [32:0] dw, dj, dk;

  always_comb begin
    mii = mat_q.right_x; mjj = mat_q.up_y;    mkk = mat_q.at_z;
    mkj = mat_q.at_y;    mjk = mat_q.up_z;
    mji = mat_q.up_x;    mij = mat_q.right_y;
    mki = mat_q.at_x;    mik = mat_q.right_z;
    case (axis_q)
      rmq_pkg::COMP_Y: begin
        mii = mat_q.up_y;    mjj = mat_q.at_z;  mkk = mat_q.right_x;
        mkj = mat_q.right_z; mjk = mat_q.at_x;
        mji = mat_q.at_y;    mij = mat_q.up_z;
        mki = mat_q.right_y; mik = mat_q.up_x;
      end
      rmq_pkg::COMP_Z: begin
        mii = mat_q.at_z;    mjj = mat_q.right_x; mkk = mat_q.up_y;
        mkj = mat_q.up_x;    mjk = mat_q.right_y;
        mji = mat_q.right_z; mij = mat_q.at_x;
        mki = mat_q.up_z;    mik = mat_q.at_y;
      end
      default: ;
    endcase

    dw = 33'(mkj) - 33'(mjk);
    dj = 33'(mji) + 33'(mij);
    dk = 33'(mki) + 33'(mik);

    item_o = '0;
    if (trace_q > 34'sd0) begin
      rad_full                     = ONE + 35'(trace_q);
      item_o.trace_pos             = 1'b1;
      item_o.half_sel              = rmq_pkg::COMP_W;
      item_o.diff[rmq_pkg::COMP_X] = 33'(mat_q.at_y) - 33'(mat_q.up_z);
      item_o.diff[rmq_pkg::COMP_Y] = 33'(mat_q.right_z) - 33'(mat_q.at_x);
      item_o.diff[rmq_pkg::COMP_Z] = 33'(mat_q.up_x) - 33'(mat_q.right_y);
    end else begin
      rad_full                     = ONE + 35'(mii) - 35'(mjj) - 35'(mkk);
      item_o.trace_pos             = 1'b0;
      item_o.half_sel              = axis_q;
      item_o.diff[rmq_pkg::COMP_W] = dw;
      case (axis_q)
        rmq_pkg::COMP_Y: begin
          item_o.diff[rmq_pkg::COMP_Z] = dj;
          item_o.diff[rmq_pkg::COMP_X] = dk;
        end
        rmq_pkg::COMP_Z: begin
          item_o.diff[rmq_pkg::COMP_X] = dj;
          item_o.diff[rmq_pkg::COMP_Y] = dk;
        end
        default: begin
          item_o.diff[rmq_pkg::COMP_Y] = dj;
          item_o.diff[rmq_pkg::COMP_Z] = dk;
        end
      endcase
    end
    // negative radicand clamps to zero
    item_o.rad = rad_full[34] ? '0 : rad_full[rmq_pkg::RAD_W-1:0];
  end

  assign push_o = a_valid_q && !q_full_i;

endmodule

`default_nettype wire

// File: src/rmq_queue.sv
// ----------------------------------------------------------------------------
// rmq_queue
// Small request queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rmq_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rmq_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rmq_pkg::item_t item_o
);

  rmq_pkg::item_t                 mem_q [rmq_pkg::QUEUE_DEPTH];
  logic [rmq_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [rmq_pkg::QCNT_W-1:0]     count_q;

  assign full_o  = (count_q == rmq_pkg::QCNT_W'(rmq_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `RMQ_ASSERT_NEVER(a_push_when_full, push_i && full_o, "queue push while full")
  `RMQ_ASSERT_NEVER(a_pop_when_empty, pop_i && empty_o, "queue pop while empty")

endmodule

`default_nettype wire

// File: src/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, scaled division per slot, sign fix and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rmq_back #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  rmq_pkg::item_t               item_i,
  output logic                         pop_o,
  input  logic [rmq_pkg::LIMIT_W-1:0]  limit_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  quat_x_o,
  output logic [31:0]                  quat_y_o,
  output logic [31:0]                  quat_z_o,
  output logic [31:0]                  quat_w_o,
  output logic                         degenerate_o
);

  localparam int unsigned ROOT_W = (rmq_pkg::RAD_W + FRAC_BITS + 1) / 2;
  localparam int unsigned SQ_W   = 2 * ROOT_W;
  localparam int unsigned SREM_W = ROOT_W + 1;
  localparam int unsigned QUO_W  = rmq_pkg::DATA_W;
  localparam int unsigned NUM_W  = rmq_pkg::DIFF_W + FRAC_BITS;
  localparam int unsigned REM_W  = ROOT_W + 1;
  localparam int unsigned CMP_W  = ROOT_W + QUO_W + 1;
  localparam logic [31:0] ONE_Q  = 32'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic [SQ_W-1:0]                        rad;
    logic [SREM_W-1:0]                      rem;
    logic [ROOT_W-1:0]                      root;
    logic [3:0][rmq_pkg::DIFF_W-1:0]        diff;
    rmq_pkg::comp_e                         half_sel;
    logic                                   trace_pos;
  } sq_t;

  typedef struct packed {
    logic [3:0][REM_W-1:0]  rem;
    logic [3:0][QUO_W-1:0]  lo;
    logic [3:0][QUO_W-1:0]  quo;
    logic [3:0]             neg;
    logic [3:0]             ovf;
    rmq_pkg::comp_e         half_sel;
    logic                   degen;
    logic [ROOT_W-1:0]      root;
  } dv_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Whole pipeline advances unless the output holds a stalled result
  logic en;
  logic out_valid_q;
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !q_empty_i;

  // Square root: one result bit per stage
  sq_t               sq_q [ROOT_W];
  logic [ROOT_W-1:0] sq_v_q;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_sq
    sq_t                src, nxt;
    logic [SREM_W+1:0]  t, trial;
    logic               ge;

    if (s == 0) begin : g_first
      always_comb begin
        src           = '0;
        src.rad       = SQ_W'(item_i.rad) << FRAC_BITS;
        src.diff      = item_i.diff;
        src.half_sel  = item_i.half_sel;
        src.trace_pos = item_i.trace_pos;
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) sq_v_q[s] <= 1'b0;
        else if (en) sq_v_q[s] <= !q_empty_i;
      end
    end else begin : g_next
      assign src = sq_q[s-1];
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) sq_v_q[s] <= 1'b0;
        else if (en) sq_v_q[s] <= sq_v_q[s-1];
      end
    end

    always_comb begin
      nxt      = src;
      t        = {src.rem, src.rad[SQ_W-1 -: 2]};
      trial    = (SREM_W+2)'({src.root, 2'b01});
      ge       = (t >= trial);
      nxt.rem  = ge ? SREM_W'(t - trial) : SREM_W'(t);
      nxt.root = {src.root[ROOT_W-2:0], ge};
      nxt.rad  = src.rad << 2;
    end

    always_ff @(posedge clk_i) begin
      if (en) sq_q[s] <= nxt;
    end
  end

  // Setup stage then long division, one quotient bit per stage per slot
  dv_t              dv_q [QUO_W+1];
  logic [QUO_W:0]   dv_v_q;

  for (genvar s = 0; s <= QUO_W; s++) begin : g_dv
    dv_t nxt;

    if (s == 0) begin : g_setup
      sq_t                          fin;
      logic [rmq_pkg::DIFF_W-1:0]   mag;
      logic [NUM_W-1:0]             num;
      assign fin = sq_q[ROOT_W-1];
      always_comb begin
        nxt          = '0;
        nxt.root     = fin.root;
        nxt.half_sel = fin.half_sel;
        nxt.degen    = !fin.trace_pos &&
                       ((fin.root == '0) || (32'(fin.root) < 32'(limit_i)));
        mag = '0;
        num = '0;
        for (int c = 0; c < 4; c++) begin
          mag        = fin.diff[c][rmq_pkg::DIFF_W-1] ? -fin.diff[c] : fin.diff[c];
          num        = NUM_W'(mag) << FRAC_BITS;
          nxt.neg[c] = fin.diff[c][rmq_pkg::DIFF_W-1];
          nxt.ovf[c] = CMP_W'(num) >= {fin.root, (QUO_W+1)'(0)};
          nxt.rem[c] = REM_W'(num >> QUO_W);
          nxt.lo[c]  = num[QUO_W-1:0];
        end
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) dv_v_q[s] <= 1'b0;
        else if (en) dv_v_q[s] <= sq_v_q[ROOT_W-1];
      end
    end else begin : g_step
      dv_t                src;
      logic [REM_W:0]     t, den;
      logic               ge;
      assign src = dv_q[s-1];
      always_comb begin
        nxt = src;
        den = (REM_W+1)'({src.root, 1'b0});
        t   = '0;
        ge  = 1'b0;
        for (int c = 0; c < 4; c++) begin
          t          = {src.rem[c], src.lo[c][QUO_W-1]};
          ge         = (t >= den);
          nxt.rem[c] = ge ? REM_W'(t - den) : REM_W'(t);
          nxt.lo[c]  = src.lo[c] << 1;
          nxt.quo[c] = {src.quo[c][QUO_W-2:0], ge};
        end
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) dv_v_q[s] <= 1'b0;
        else if (en) dv_v_q[s] <= dv_v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) dv_q[s] <= nxt;
    end
  end

  // Final: pick half-root slot, flip on negative w, saturate; identity if degenerate
  dv_t                 lst;
  logic [3:0][32:0]    mag_f;
  logic                wneg;
  logic signed [33:0]  val;
  logic [3:0][31:0]    res_d, res_q;
  logic                degen_q;

  assign lst = dv_q[QUO_W];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (rmq_pkg::comp_e'(c) == lst.half_sel) begin
        mag_f[c] = 33'(lst.root >> 1);
      end else if (lst.ovf[c]) begin
        mag_f[c] = 33'h1_0000_0000;
      end else begin
        mag_f[c] = {1'b0, lst.quo[c]};
      end
    end
    wneg = (lst.half_sel != rmq_pkg::COMP_W) && lst.neg[rmq_pkg::COMP_W] &&
           (mag_f[rmq_pkg::COMP_W] != '0);
    val  = '0;
    for (int c = 0; c < 4; c++) begin
      val = (lst.neg[c] ^ wneg) ? -$signed({1'b0, mag_f[c]}) : $signed({1'b0, mag_f[c]});
      res_d[c] = sat32(val);
    end
    if (lst.degen) begin
      res_d                  = '0;
      res_d[rmq_pkg::COMP_W] = ONE_Q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= dv_v_q[QUO_W];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q   <= res_d;
      degen_q <= lst.degen;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign quat_x_o     = res_q[rmq_pkg::COMP_X];
  assign quat_y_o     = res_q[rmq_pkg::COMP_Y];
  assign quat_z_o     = res_q[rmq_pkg::COMP_Z];
  assign quat_w_o     = res_q[rmq_pkg::COMP_W];
  assign degenerate_o = degen_q;

  `RMQ_ASSERT(a_w_nonneg, out_valid_q |-> !quat_w_o[31], "quaternion w left negative")

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rotation_matrix_to_quaternion_top. Every accepted
// matrix goes through a local bit-exact predictor (trace path, largest-axis
// path, clamped radicand, sign flip, saturation). Each result that comes out
// is checked in order against the oldest prediction. The bench writes the
// near-zero limit between phases and varies idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE        = 64'sd1 << 30;
  localparam int     UNIT       = 32'sd1 << 30;
  localparam int     DRAIN_WAIT = 80;
  localparam int     CYCLE_CAP  = 2000000;

  typedef struct packed {
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic signed [31:0] qw;
    logic               degen;
  } quat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [30:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [31:0] right_x_i, right_y_i, right_z_i;
  logic signed [31:0] up_x_i, up_y_i, up_z_i;
  logic signed [31:0] at_x_i, at_y_i, at_z_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [31:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;
  logic degenerate_o;

  rmq_pkg::mat_t pending_mats[$];
  quat_t expected_quats[$];
  logic [30:0] limit_now;
  int send_idle_pct;
  int recv_idle_pct;
  int n_errors;
  int n_accepted;
  int n_checked;
  int n_degen;
  int hold_left;
  bit hold_done;
  longint cycles;

  rotation_matrix_to_quaternion_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .right_x_i    (right_x_i),
    .right_y_i    (right_y_i),
    .right_z_i    (right_z_i),
    .up_x_i       (up_x_i),
    .up_y_i       (up_y_i),
    .up_z_i       (up_z_i),
    .at_x_i       (at_x_i),
    .at_y_i       (at_y_i),
    .at_z_i       (at_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o),
    .quat_w_o     (quat_w_o),
    .degenerate_o (degenerate_o)
  );

  // Clock, reset and run limit
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Bit-serial integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // (d << 30) / (2 * root), truncated toward zero
  function automatic longint frac_div(longint d, longint unsigned root);
    longint num;
    longint den;
    num = d * ONE;
    den = longint'(2 * root);
    return num / den;
  endfunction

  // Expected quaternion for one matrix under a given near-zero limit
  function automatic quat_t predict_quat(rmq_pkg::mat_t mt, logic [30:0] lim);
    longint e[3][3];
    longint q[4];
    longint tr, rad;
    longint unsigned root;
    int ax, j, k;
    quat_t res;
    e[0][0] = mt.right_x; e[0][1] = mt.right_y; e[0][2] = mt.right_z;
    e[1][0] = mt.up_x;    e[1][1] = mt.up_y;    e[1][2] = mt.up_z;
    e[2][0] = mt.at_x;    e[2][1] = mt.at_y;    e[2][2] = mt.at_z;
    res.degen = 1'b0;
    tr = e[0][0] + e[1][1] + e[2][2];
    if (tr > 0) begin
      rad = ONE + tr;
      root = int_sqrt(longint'(rad) << 30);
      q[rmq_pkg::COMP_W] = longint'(root >> 1);
      q[rmq_pkg::COMP_X] = frac_div(e[2][1] - e[1][2], root);
      q[rmq_pkg::COMP_Y] = frac_div(e[0][2] - e[2][0], root);
      q[rmq_pkg::COMP_Z] = frac_div(e[1][0] - e[0][1], root);
    end else begin
      ax = rmq_pkg::COMP_X;
      if (e[1][1] > e[0][0]) ax = rmq_pkg::COMP_Y;
      if (e[2][2] > e[ax][ax]) ax = rmq_pkg::COMP_Z;
      j = (ax + 1) % 3;
      k = (j + 1) % 3;
      rad = ONE + e[ax][ax] - e[j][j] - e[k][k];
      if (rad < 0) rad = 0;
      root = int_sqrt(longint'(rad) << 30);
      if (root == 0 || root < longint'(lim)) begin
        q[rmq_pkg::COMP_X] = 0; q[rmq_pkg::COMP_Y] = 0; q[rmq_pkg::COMP_Z] = 0;
        q[rmq_pkg::COMP_W] = ONE;
        res.degen = 1'b1;
      end else begin
        q[ax] = longint'(root >> 1);
        q[rmq_pkg::COMP_W] = frac_div(e[k][j] - e[j][k], root);
        q[j] = frac_div(e[j][ax] + e[ax][j], root);
        q[k] = frac_div(e[k][ax] + e[ax][k], root);
        // keep w non-negative
        if (q[rmq_pkg::COMP_W] < 0) begin
          q[0] = -q[0]; q[1] = -q[1]; q[2] = -q[2]; q[3] = -q[3];
        end
      end
    end
    res.qx = clip32(q[rmq_pkg::COMP_X]);
    res.qy = clip32(q[rmq_pkg::COMP_Y]);
    res.qz = clip32(q[rmq_pkg::COMP_Z]);
    res.qw = clip32(q[rmq_pkg::COMP_W]);
    return res;
  endfunction

  // Request driver: holds payload while stalled, idles at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      {right_x_i, right_y_i, right_z_i} <= '0;
      {up_x_i, up_y_i, up_z_i} <= '0;
      {at_x_i, at_y_i, at_z_i} <= '0;
      n_accepted <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_quats.push_back(predict_quat(pending_mats[0], limit_now));
        void'(pending_mats.pop_front());
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_mats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          right_x_i <= pending_mats[0].right_x;
          right_y_i <= pending_mats[0].right_y;
          right_z_i <= pending_mats[0].right_z;
          up_x_i    <= pending_mats[0].up_x;
          up_y_i    <= pending_mats[0].up_y;
          up_z_i    <= pending_mats[0].up_z;
          at_x_i    <= pending_mats[0].at_x;
          at_y_i    <= pending_mats[0].at_y;
          at_z_i    <= pending_mats[0].at_z;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks in order, stalls at random, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    quat_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_quats.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          want = expected_quats.pop_front();
          n_checked++;
          if (want.degen) n_degen++;
          if (quat_x_o !== want.qx) begin
            $error("quat_x expected %0d got %0d", want.qx, quat_x_o); n_errors++;
          end
          if (quat_y_o !== want.qy) begin
            $error("quat_y expected %0d got %0d", want.qy, quat_y_o); n_errors++;
          end
          if (quat_z_o !== want.qz) begin
            $error("quat_z expected %0d got %0d", want.qz, quat_z_o); n_errors++;
          end
          if (quat_w_o !== want.qw) begin
            $error("quat_w expected %0d got %0d", want.qw, quat_w_o); n_errors++;
          end
          if (degenerate_o !== want.degen) begin
            $error("degenerate expected %0b got %0b", want.degen, degenerate_o);
            n_errors++;
          end
        end
      end
      if (!hold_done && n_accepted >= 120) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic rmq_pkg::mat_t diag_mat(int a, int b, int c);
    rmq_pkg::mat_t mt;
    mt = '0;
    mt.right_x = a;
    mt.up_y = b;
    mt.at_z = c;
    return mt;
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return 32'h40000000;
      4: return 32'hc0000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] to_fix(real r);
    return clip32($rtoi(r * 1073741824.0));
  endfunction

  // Mostly true rotations with small noise, some raw or extreme words
  function automatic rmq_pkg::mat_t rand_mat();
    rmq_pkg::mat_t mt;
    real a, b, c, d, n;
    int kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      a = $urandom_range(2000) / 1000.0 - 1.0;
      b = $urandom_range(2000) / 1000.0 - 1.0;
      c = $urandom_range(2000) / 1000.0 - 1.0;
      d = $urandom_range(2000) / 1000.0 - 1.0;
      // push some toward half-turns so the axis paths get exercised
      if (kind == 5) d = d / 50.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
      a = a / n; b = b / n; c = c / n; d = d / n;
      mt.right_x = to_fix(1.0 - 2.0 * (b * b + c * c));
      mt.right_y = to_fix(2.0 * (a * b + c * d));
      mt.right_z = to_fix(2.0 * (a * c - b * d));
      mt.up_x    = to_fix(2.0 * (a * b - c * d));
      mt.up_y    = to_fix(1.0 - 2.0 * (a * a + c * c));
      mt.up_z    = to_fix(2.0 * (b * c + a * d));
      mt.at_x    = to_fix(2.0 * (a * c + b * d));
      mt.at_y    = to_fix(2.0 * (b * c - a * d));
      mt.at_z    = to_fix(1.0 - 2.0 * (a * a + b * b));
      mt.right_x = mt.right_x + $signed($urandom_range(64)) - 32;
      mt.at_y    = mt.at_y + $signed($urandom_range(64)) - 32;
    end else if (kind < 8) begin
      mt = {$urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
    end else begin
      mt = {edge_word(), edge_word(), edge_word(), edge_word(), edge_word(),
            edge_word(), edge_word(), edge_word(), edge_word()};
    end
    return mt;
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_mats.size() != 0 || in_valid_i || expected_quats.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [30:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_now = val;
  endtask

  task automatic queue_random(int cnt);
    repeat (cnt) pending_mats.push_back(rand_mat());
  endtask

  // Stimulus and phase control
  initial begin
    rmq_pkg::mat_t mt;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    limit_now = rmq_pkg::LIMIT_RESET;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_errors = 0;
    n_checked = 0;
    n_degen = 0;
    cycles = 0;
    @(posedge rst_ni);
    repeat (2) @(posedge clk_i);

    // directed: identity, half-turns, zero, ties, extremes, negative w
    pending_mats.push_back(diag_mat(UNIT, UNIT, UNIT));
    pending_mats.push_back(diag_mat(UNIT, -UNIT, -UNIT));
    pending_mats.push_back(diag_mat(-UNIT, UNIT, -UNIT));
    pending_mats.push_back(diag_mat(-UNIT, -UNIT, UNIT));
    pending_mats.push_back(diag_mat(-UNIT, -UNIT, -UNIT));
    pending_mats.push_back(diag_mat(0, 0, 0));
    pending_mats.push_back(diag_mat(UNIT, -UNIT, 0));
    pending_mats.push_back(diag_mat(-5, -5, 10));
    pending_mats.push_back(diag_mat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_mats.push_back(diag_mat(32'h80000000, 32'h80000000, 32'h80000000));
    pending_mats.push_back(diag_mat(32'h7fffffff, 32'h80000000, 32'h80000000));
    pending_mats.push_back({9{32'h7fffffff}});
    pending_mats.push_back({9{32'h80000000}});
    pending_mats.push_back({9{32'hffffffff}});
    mt = diag_mat(UNIT, -UNIT, -UNIT);
    mt.at_y = 32'h7fffffff; mt.up_z = 32'h80000000;   // w > 0 after axis path, swapped below for w < 0
    pending_mats.push_back(mt);
    mt.at_y = 32'h80000000; mt.up_z = 32'h7fffffff;
    pending_mats.push_back(mt);
    mt = diag_mat(1, 1, 1);
    mt.at_y = 32'h7fffffff; mt.up_z = 32'h80000000;   // trace path saturation
    pending_mats.push_back(mt);
    mt = diag_mat(0, 0, 0);
    mt.up_x = 32'h7fffffff; mt.right_y = 32'h80000000;
    pending_mats.push_back(mt);
    pending_mats.push_back(diag_mat(0, 1, -1));
    wait_drained();

    // phase A: limit zero, sender idle 36%, receiver mostly stalled
    write_limit(31'd0);
    send_idle_pct = 36;
    recv_idle_pct = 80;
    queue_random(230);
    wait_drained();

    // phase B: top limit, zero matrix sits on the boundary
    write_limit(31'd1073741824);
    send_idle_pct = 80;
    recv_idle_pct = 36;
    pending_mats.push_back(diag_mat(0, 0, 0));
    pending_mats.push_back(diag_mat(-UNIT, -UNIT, -UNIT));
    queue_random(230);
    wait_drained();

    // phase C: random limit, full rate both ways
    write_limit(31'($urandom_range(1073741824)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(230);
    wait_drained();
    write_limit(rmq_pkg::LIMIT_RESET);
    queue_random(10);
    wait_drained();

    $display("checked %0d quaternions (%0d degenerate) over %0d requests,",
             n_checked, n_degen, n_accepted);
    $display("limits 0, 2^30, random and reset value; mixed idling and a long hold-off");
    if (n_errors == 0 && expected_quats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+src
src/rmq_pkg.sv
src/rmq_front.sv
src/rmq_queue.sv
src/rmq_back.sv
src/rotation_matrix_to_quaternion_top.sv
sim/testbench.sv
